/* hw/rtl/udp_client_session_table_macros.svh */
// Assertion helpers shared by the session table modules.
`ifndef UDP_CLIENT_SESSION_TABLE_MACROS_SVH
`define UDP_CLIENT_SESSION_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define UCST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define UCST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ucst_pkg.sv */
package ucst_pkg;

    localparam int PROTO_W  = 8;
    localparam int PORT_W   = 16;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;

    localparam logic [PROTO_W-1:0] UDP_PROTO_NUM = 8'd17;

    typedef enum logic [STATUS_W-1:0] {
        ST_COUNTED      = 3'd0,
        ST_FILTERED     = 3'd1,
        ST_CLOSED       = 3'd2,
        ST_EXIT_UNKNOWN = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_FETCH,
        S_UPDATE,
        S_CLOSE,
        S_EMIT
    } t_ctl_state;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_CLOSE,
        WR_COUNT
    } t_wr_kind;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [PORT_W-1:0]  port;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic     load;
        logic     start;
        logic     set_tgt;
        logic     fetch;
        t_wr_kind wr;
        logic     emit;
        t_status  status;
    } t_ctl_cmd;

    typedef struct packed {
        logic filtered;
        logic clr_last;
        logic scan_done;
        logic found;
        logic free_found;
        logic is_exit;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/ucst_if.sv */
interface ucst_in_if import ucst_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PROTO_W-1:0] ip_protocol;
    logic [PORT_W-1:0]  dest_port;
    logic [ADDR_W-1:0]  client_ip;
    logic [PORT_W-1:0]  source_port;
    logic               is_exit;

    modport source (
        output valid, ip_protocol, dest_port, client_ip, source_port, is_exit,
        input  ready
    );
    modport sink (
        input  valid, ip_protocol, dest_port, client_ip, source_port, is_exit,
        output ready
    );
endinterface

interface ucst_out_if import ucst_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, status, slot, count, input ready);
    modport sink   (input valid, status, slot, count, output ready);
endinterface

/* hw/rtl/ucst_ctrl.sv */
`include "udp_client_session_table_macros.svh"

module ucst_ctrl import ucst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    t_ctl_state r_state, n_state;
    t_status    r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.set_tgt = 1'b0;
        o_cmd.fetch   = 1'b0;
        o_cmd.wr      = WR_NONE;
        o_cmd.emit    = 1'b0;
        o_cmd.status  = r_status;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.filtered) begin
                    n_status = ST_FILTERED;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.set_tgt = 1'b1;
                if (i_stat.is_exit) begin
                    if (i_stat.found) begin
                        n_state = S_CLOSE;
                    end else begin
                        n_status = ST_EXIT_UNKNOWN;
                        n_state  = S_EMIT;
                    end
                end else if (i_stat.found) begin
                    n_state = S_FETCH;
                end else if (i_stat.free_found) begin
                    n_state = S_UPDATE;
                end else begin
                    n_status = ST_FULL;
                    n_state  = S_EMIT;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.wr = WR_COUNT;
                n_status = ST_COUNTED;
                n_state  = S_EMIT;
            end
            S_CLOSE: begin
                o_cmd.wr = WR_CLOSE;
                n_status = ST_CLOSED;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    `UCST_ASSERT_NXT(a_accept_to_check, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CHECK, "accepted word did not move to check")
    `UCST_ASSERT_IMP(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN, o_cmd.wr == WR_NONE, "table written during scan")
    `UCST_ASSERT_IMP(a_emit_when_free, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free, "result emitted over a pending word")

endmodule

/* hw/rtl/ucst_datapath.sv */
`include "udp_client_session_table_macros.svh"

module ucst_datapath import ucst_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int BANK_BITS     = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PORT_W-1:0]   i_cfg_wr_data,
    input  logic [PROTO_W-1:0]  i_ip_protocol,
    input  logic [PORT_W-1:0]   i_dest_port,
    input  logic [ADDR_W-1:0]   i_client_ip,
    input  logic [PORT_W-1:0]   i_source_port,
    input  logic                i_is_exit,
    input  t_ctl_cmd            i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output t_status             o_out_status,
    output logic [SLOT_W-1:0]   o_out_slot,
    output logic [COUNT_W-1:0]  o_out_count
);

    localparam int BANKS = 1 << BANK_BITS;
    localparam int ROWS  = (TABLE_ENTRIES + BANKS - 1) / BANKS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + BANK_BITS;
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [IDX_W:0]   ENTRY_LIM = (IDX_W + 1)'(TABLE_ENTRIES);

    // config and captured word
    logic [PORT_W-1:0]  r_listen_port;
    logic [PROTO_W-1:0] r_proto;
    logic [PORT_W-1:0]  r_dport;
    logic [ADDR_W-1:0]  r_saddr;
    logic [PORT_W-1:0]  r_sport;
    logic               r_is_exit;

    // scan pipeline
    logic [ROW_W-1:0]     r_clr_row;
    logic [ROW_W-1:0]     r_scan_row;
    logic                 r_issue;
    logic                 r_p1_vld;
    logic [ROW_W-1:0]     r_p1_row;
    logic                 r_p2_vld;
    logic [ROW_W-1:0]     r_p2_row;
    logic [BANKS-1:0]     r_match_vec;
    logic [BANKS-1:0]     r_free_vec;
    logic [BANKS-1:0]     match_c;
    logic [BANKS-1:0]     free_c;
    logic                 match_hit;
    logic [BANK_BITS-1:0] match_lane;
    logic                 free_hit;
    logic [BANK_BITS-1:0] free_lane;

    // lookup results and target entry
    logic                 r_found;
    logic [ROW_W-1:0]     r_hit_row;
    logic [BANK_BITS-1:0] r_hit_lane;
    logic                 r_free_found;
    logic [ROW_W-1:0]     r_free_row;
    logic [BANK_BITS-1:0] r_free_lane;
    logic [ROW_W-1:0]     r_tgt_row;
    logic [BANK_BITS-1:0] r_tgt_lane;
    logic                 r_claim;
    logic [COUNT_W-1:0]   r_new_cnt;

    // memory access
    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   wr_row;
    t_entry             wr_data;
    logic [BANKS-1:0]   wr_en;
    logic [COUNT_W-1:0] q_cnt [BANKS];
    logic [COUNT_W-1:0] sel_cnt;
    logic [COUNT_W-1:0] upd_cnt;

    // output word
    logic               r_out_vld;
    t_status            r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [COUNT_W-1:0] r_out_count;

    assign rd_row = i_cmd.fetch ? r_tgt_row : r_scan_row;

    always_comb begin
        wr_row  = r_tgt_row;
        wr_data = '0;
        wr_en   = '0;
        case (i_cmd.wr)
            WR_CLEAR: begin
                wr_row = r_clr_row;
                wr_en  = '1;
            end
            WR_CLOSE: begin
                wr_en[r_tgt_lane] = 1'b1;
            end
            WR_COUNT: begin
                wr_data.valid = 1'b1;
                wr_data.addr  = r_saddr;
                wr_data.port  = r_sport;
                wr_data.count = upd_cnt;
                wr_en[r_tgt_lane] = 1'b1;
            end
            default: begin
                wr_en = '0;
            end
        endcase
    end

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        t_entry r_mem [ROWS];
        t_entry r_q;
        logic   lane_ok;

        always_ff @(posedge i_clk) begin
            if (wr_en[b]) begin
                r_mem[wr_row] <= wr_data;
            end
            r_q <= r_mem[rd_row];
        end

        // lanes past the end of the table in the last row never take part
        assign lane_ok    = ({1'b0, r_p1_row, BANK_BITS'(b)} < ENTRY_LIM);
        assign match_c[b] = lane_ok && r_q.valid && (r_q.addr == r_saddr)
                            && (r_q.port == r_sport);
        assign free_c[b]  = lane_ok && !r_q.valid;
        assign q_cnt[b]   = r_q.count;
    end

    // lowest lane wins
    always_comb begin
        match_hit  = 1'b0;
        match_lane = '0;
        free_hit   = 1'b0;
        free_lane  = '0;
        for (int b = BANKS - 1; b >= 0; b--) begin
            if (r_match_vec[b]) begin
                match_hit  = 1'b1;
                match_lane = BANK_BITS'(b);
            end
            if (r_free_vec[b]) begin
                free_hit  = 1'b1;
                free_lane = BANK_BITS'(b);
            end
        end
    end

    assign sel_cnt = q_cnt[r_tgt_lane];
    assign upd_cnt = r_claim ? COUNT_W'(1) : ((&sel_cnt) ? sel_cnt : sel_cnt + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_port <= '0;
            r_clr_row     <= '0;
            r_scan_row    <= '0;
            r_issue       <= 1'b0;
            r_p1_vld      <= 1'b0;
            r_p2_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_free_found  <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_listen_port <= i_cfg_wr_data;
            end
            if (i_cmd.wr == WR_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (i_cmd.start) begin
                r_scan_row   <= '0;
                r_issue      <= 1'b1;
                r_p1_vld     <= 1'b0;
                r_p2_vld     <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (r_issue) begin
                    r_scan_row <= r_scan_row + 1'b1;
                    if (r_scan_row == LAST_ROW) begin
                        r_issue <= 1'b0;
                    end
                end
                r_p1_vld <= r_issue;
                r_p2_vld <= r_p1_vld;
                if (r_p2_vld && free_hit) begin
                    r_free_found <= 1'b1;
                end
                // first match ends the scan; flush reads still in flight
                if (r_p2_vld && match_hit) begin
                    r_found  <= 1'b1;
                    r_issue  <= 1'b0;
                    r_p1_vld <= 1'b0;
                    r_p2_vld <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_proto   <= i_ip_protocol;
            r_dport   <= i_dest_port;
            r_saddr   <= i_client_ip;
            r_sport   <= i_source_port;
            r_is_exit <= i_is_exit;
        end
        r_p1_row    <= r_scan_row;
        r_p2_row    <= r_p1_row;
        r_match_vec <= match_c;
        r_free_vec  <= free_c;
        if (r_p2_vld && match_hit) begin
            r_hit_row  <= r_p2_row;
            r_hit_lane <= match_lane;
        end
        if (r_p2_vld && free_hit && !r_free_found) begin
            r_free_row  <= r_p2_row;
            r_free_lane <= free_lane;
        end
        if (i_cmd.set_tgt) begin
            r_tgt_row  <= r_found ? r_hit_row : r_free_row;
            r_tgt_lane <= r_found ? r_hit_lane : r_free_lane;
            r_claim    <= !r_found;
        end
        if (i_cmd.wr == WR_COUNT) begin
            r_new_cnt <= upd_cnt;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_slot   <= (i_cmd.status == ST_CLOSED || i_cmd.status == ST_COUNTED)
                            ? SLOT_W'({r_tgt_row, r_tgt_lane}) : '0;
            r_out_count  <= (i_cmd.status == ST_COUNTED) ? r_new_cnt : '0;
        end
    end

    assign o_stat.filtered   = (r_proto != UDP_PROTO_NUM) || (r_dport != r_listen_port);
    assign o_stat.clr_last   = (r_clr_row == LAST_ROW);
    assign o_stat.scan_done  = r_found || !(r_issue || r_p1_vld || r_p2_vld);
    assign o_stat.found      = r_found;
    assign o_stat.free_found = r_free_found;
    assign o_stat.is_exit    = r_is_exit;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;
    assign o_out_count  = r_out_count;

    `UCST_ASSERT_IMP(a_found_flushes, i_clk, i_rst_n, r_found, !r_issue && !r_p1_vld && !r_p2_vld, "scan pipeline live after match")
    `UCST_ASSERT_IMP(a_counted_nonzero, i_clk, i_rst_n, i_cmd.emit && (i_cmd.status == ST_COUNTED), r_new_cnt != '0, "counted word with zero count")
    `UCST_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_out_vld && !i_out_ready, r_out_vld, "pending result word dropped")

endmodule

/* hw/rtl/udp_client_session_table.sv */
// Channel  | dir | handshake     | word
// ---------+-----+---------------+----------------------------------------------
// i_in     | in  | valid / ready | ip_protocol, dest_port, client_ip,
//          |     |               | source_port, is_exit
// o_out    | out | valid / ready | status, slot, count
// cfg      | in  | i_cfg_wr_en   | i_cfg_wr_data = listen_port
//
// Scan: a lookup scans BANKS entries per cycle from one row of the bank memories,
//   row by row over all ROWS rows (ROWS = TABLE_ENTRIES / BANKS, rounded up),
//   and ends early when a match is found. A new word is taken only once the
//   result of the last one has gone into the output register.
// Reset: synchronous, active low. After reset a clearing pass writes every row
//   invalid, row by row; no word is taken until it ends.
// Stalls: the result sits in an output register, so the next word is accepted
//   while it waits; a new result waits until that register frees up.
//
// The lookup is keyed by (client_ip, source_port). Entries are held in
// BANKS parallel memories, entry index = {row, bank}, so the lowest matching
// or lowest free entry is the first one found in row order, then bank order.
// Exit words free a matching entry; other words count on the match or claim
// the first free entry. Message counts saturate at all ones.
module udp_client_session_table import ucst_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024,  // 1 .. 1024; the slot output is 10 bits
    parameter int BANK_BITS     = 6      // entries compared per cycle = 2**BANK_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ucst_in_if.sink           i_in,
    ucst_out_if.source        o_out,
    input  logic              i_cfg_wr_en,
    input  logic [PORT_W-1:0] i_cfg_wr_data
);

    t_ctl_cmd           cmd;
    t_dp_stat           stat;
    logic               in_ready;
    logic               out_valid;
    t_status            out_status;
    logic [SLOT_W-1:0]  out_slot;
    logic [COUNT_W-1:0] out_count;

    ucst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ucst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BANK_BITS     (BANK_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_ip_protocol    (i_in.ip_protocol),
        .i_dest_port      (i_in.dest_port),
        .i_client_ip      (i_in.client_ip),
        .i_source_port    (i_in.source_port),
        .i_is_exit        (i_in.is_exit),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (out_valid),
        .o_out_status     (out_status),
        .o_out_slot       (out_slot),
        .o_out_count      (out_count)
    );

    assign i_in.ready   = in_ready;
    assign o_out.valid  = out_valid;
    assign o_out.status = out_status;
    assign o_out.slot   = out_slot;
    assign o_out.count  = out_count;

endmodule

/* verif/tb_udp_client_session_table.sv */
`timescale 1ns / 1ps

module tb_udp_client_session_table import ucst_pkg::*;;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ITEMS         = 1550;
    localparam int POOL          = 24;
    localparam int CALM_TAIL     = 100;   // last words run with no idling
    localparam int DRAIN_LIMIT   = 5000;

    // One datagram as the input word sees it.
    typedef struct packed {
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  dport;
        logic [ADDR_W-1:0]  addr;
        logic [PORT_W-1:0]  sport;
        logic               is_exit;
    } t_dgram;

    // One reply word.
    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_reply;

    // Directed step: the reply is either typed in (KNOWN) or left to the tracker (PRED).
    typedef struct packed {
        t_dgram dg;
        logic   typed;
        t_reply want;
    } t_row;

    localparam logic   MSG       = 1'b0;
    localparam logic   QUIT      = 1'b1;
    localparam logic   KNOWN     = 1'b1;
    localparam logic   PRED      = 1'b0;
    localparam t_reply ANY_REPLY = '{ST_COUNTED, 10'd0, 32'd0};
    localparam int     DIR_ROWS  = 22;

    // Directed part, run with listen_port still at its reset value of 0.
    // Covers claim/count, filtering on each side of UDP and on the port, exit on
    // a known and an unknown client, reuse of the lowest freed slot, and clients
    // that share only the address or only the port with an open session.
    t_row dir_rows [DIR_ROWS] = '{
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h0000_0000, 16'h0000, MSG},  KNOWN,
          '{ST_COUNTED, 10'd0, 32'd1}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h0000_0000, 16'h0000, MSG},  KNOWN,
          '{ST_COUNTED, 10'd0, 32'd2}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, MSG},  KNOWN,
          '{ST_COUNTED, 10'd1, 32'd1}},
        '{'{8'd6,          16'h0000, 32'h0000_0000, 16'h0000, MSG},  KNOWN,
          '{ST_FILTERED, 10'd0, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'hFFFF, 32'h0000_0000, 16'h0000, MSG},  KNOWN,
          '{ST_FILTERED, 10'd0, 32'd0}},
        '{'{8'hFF,         16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, QUIT}, KNOWN,
          '{ST_FILTERED, 10'd0, 32'd0}},
        '{'{8'h00,         16'h0000, 32'h0000_0001, 16'h0001, QUIT}, KNOWN,
          '{ST_FILTERED, 10'd0, 32'd0}},
        '{'{8'd16,         16'h0000, 32'h0000_0000, 16'h0000, MSG},  KNOWN,
          '{ST_FILTERED, 10'd0, 32'd0}},
        '{'{8'd18,         16'h0000, 32'h0000_0000, 16'h0000, MSG},  KNOWN,
          '{ST_FILTERED, 10'd0, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h0000_0001, 16'h0001, QUIT}, KNOWN,
          '{ST_EXIT_UNKNOWN, 10'd0, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h0000_0000, 16'h0000, QUIT}, KNOWN,
          '{ST_CLOSED, 10'd0, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h0000_0000, 16'h0000, QUIT}, KNOWN,
          '{ST_EXIT_UNKNOWN, 10'd0, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h1234_5678, 16'h0050, MSG},  PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h1234_5678, 16'h0051, MSG},  PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h1234_5679, 16'h0050, MSG},  PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, QUIT}, KNOWN,
          '{ST_CLOSED, 10'd1, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'hA5A5_A5A5, 16'h5A5A, MSG},  PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h1234_5678, 16'h0050, MSG},  PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h5A5A_5A5A, 16'hA5A5, QUIT}, KNOWN,
          '{ST_EXIT_UNKNOWN, 10'd0, 32'd0}},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h1234_5678, 16'h0051, QUIT}, PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h8000_0000, 16'h8000, MSG},  PRED, ANY_REPLY},
        '{'{UDP_PROTO_NUM, 16'h0000, 32'h0000_0001, 16'h0001, MSG},  PRED, ANY_REPLY}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [PORT_W-1:0] cfg_wr_data = '0;

    ucst_in_if  in_if ();
    ucst_out_if out_if ();

    udp_client_session_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the session table and of listen_port.
    logic              sess_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] sess_addr  [TABLE_ENTRIES];
    logic [PORT_W-1:0] sess_port  [TABLE_ENTRIES];
    logic [COUNT_W-1:0] sess_count [TABLE_ENTRIES];
    logic [PORT_W-1:0] listen_cfg = '0;
    int                n_open     = 0;

    t_reply pending_replies [$];   // replies owed, oldest first

    // Driver-to-monitor hand-off for the word currently on the bus.
    logic   pend_typed = 1'b0;
    t_reply pend_want  = ANY_REPLY;

    // Idling controls, flipped by the stimulus thread.
    logic gaps_on   = 1'b1;
    logic stalls_on = 1'b1;
    int   stall_left = 0;

    int n_errors  = 0;
    int n_taken   = 0;
    int n_checked = 0;
    int status_tally [5] = '{0, 0, 0, 0, 0};

    initial forever #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Watchdog expired: %0d words taken, %0d replies checked, %0d owed",
                 n_taken, n_checked, pending_replies.size());
        $display("Test completed with failures");
        $finish;
    end

    function void note_error(string what);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR @%0t: %s", $time, what);
    endfunction

    // Applies one accepted datagram to the shadow table and returns its reply.
    // Lookup and claim both take the lowest index, same as the scan order in
    // the block. Count saturation at all ones can't be reached from the ports
    // in any sane run time, but the shadow keeps the rule anyway.
    function automatic t_reply track_session(t_dgram dg);
        t_reply rep;
        int     hit;
        rep = ANY_REPLY;
        rep.status = ST_FILTERED;
        hit = -1;
        if (dg.proto != UDP_PROTO_NUM || dg.dport != listen_cfg)
            return rep;
        for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
            if (sess_valid[i] && sess_addr[i] == dg.addr && sess_port[i] == dg.sport)
                hit = i;
        if (dg.is_exit) begin
            if (hit < 0) begin
                rep.status = ST_EXIT_UNKNOWN;
            end else begin
                sess_valid[hit] = 1'b0;
                n_open--;
                rep.status = ST_CLOSED;
                rep.slot   = SLOT_W'(hit);
            end
            return rep;
        end
        for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
            if (!sess_valid[i]) begin
                sess_valid[i] = 1'b1;
                sess_addr[i]  = dg.addr;
                sess_port[i]  = dg.sport;
                sess_count[i] = '0;
                n_open++;
                hit = i;
            end
        if (hit < 0) begin
            rep.status = ST_FULL;
            return rep;
        end
        if (sess_count[hit] != '1)
            sess_count[hit]++;
        rep.status = ST_COUNTED;
        rep.slot   = SLOT_W'(hit);
        rep.count  = sess_count[hit];
        return rep;
    endfunction

    // Well-formed datagram from a given client to the current listen port.
    function automatic t_dgram client_dgram(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                                            logic quit);
        t_dgram dg;
        dg = '{UDP_PROTO_NUM, listen_cfg, addr, port, quit};
        return dg;
    endfunction

    // Datagram from a client that holds a session right now, or a fresh one
    // if the table is empty.
    function automatic t_dgram open_client(logic quit);
        int start;
        int idx;
        start = $urandom_range(0, TABLE_ENTRIES - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            idx = (start + i) % TABLE_ENTRIES;
            if (sess_valid[idx])
                return client_dgram(sess_addr[idx], sess_port[idx], quit);
        end
        return client_dgram(ADDR_W'($urandom), PORT_W'($urandom), quit);
    endfunction

    // Random junk; mostly filtered, now and then a stray claim.
    function automatic t_dgram noise_dgram();
        t_dgram dg;
        dg = '{PROTO_W'($urandom), PORT_W'($urandom), ADDR_W'($urandom),
               PORT_W'($urandom), 1'($urandom)};
        case ($urandom_range(0, 2))
            0: dg.proto = UDP_PROTO_NUM;   // right protocol, stray port
            1: dg.dport = listen_cfg;      // right port, stray protocol
            default: ;
        endcase
        return dg;
    endfunction

    // Puts one word on the input channel and returns at the falling edge after
    // it was taken. valid stays high on return so back-to-back words need no
    // second assignment in one time step.
    task automatic send_dgram(t_dgram dg, logic typed, t_reply want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.ip_protocol <= dg.proto;
        in_if.dest_port   <= dg.dport;
        in_if.client_ip   <= dg.addr;
        in_if.source_port <= dg.sport;
        in_if.is_exit     <= dg.is_exit;
        pend_typed = typed;
        pend_want  = want;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Quiesce the block (every reply back), then rewrite listen_port.
    task automatic set_listen_port(logic [PORT_W-1:0] port);
        in_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= port;
        @(negedge i_clk);
        cfg_wr_en  <= 1'b0;
        listen_cfg = port;
    endtask

    // Sink side: ready drops in random bursts while stalls are enabled.
    always @(negedge i_clk) begin
        if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor: check each reply word against the oldest one owed, then log any
    // word taken this edge. A reply never comes out on the edge its word goes
    // in, so the order of the two halves doesn't matter.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        t_dgram dg;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = '{t_status'(out_if.status), out_if.slot, out_if.count};
                if (pending_replies.size() == 0) begin
                    note_error($sformatf("reply with nothing owed: status %0d slot %0d count %0d",
                                         got.status, got.slot, got.count));
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.count !== want.count)
                        note_error($sformatf({"reply %0d: expected status %0d slot %0d ",
                                              "count %0d, got status %0d slot %0d count %0d"},
                                             n_checked, want.status, want.slot, want.count,
                                             got.status, got.slot, got.count));
                    status_tally[int'(want.status)]++;
                    n_checked++;
                end
            end
            if (in_if.valid && in_if.ready) begin
                dg = '{in_if.ip_protocol, in_if.dest_port, in_if.client_ip,
                       in_if.source_port, in_if.is_exit};
                want = track_session(dg);
                if (pend_typed)
                    want = pend_want;
                pending_replies.push_back(want);
                n_taken++;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] pool_addr [POOL];
        logic [PORT_W-1:0] pool_port [POOL];
        t_dgram            dg;
        int                pick;
        int                waited;

        foreach (sess_valid[i]) begin
            sess_valid[i] = 1'b0;
            sess_addr[i]  = '0;
            sess_port[i]  = '0;
            sess_count[i] = '0;
        end
        in_if.valid       = 1'b0;
        in_if.ip_protocol = '0;
        in_if.dest_port   = '0;
        in_if.client_ip   = '0;
        in_if.source_port = '0;
        in_if.is_exit     = 1'b0;
        out_if.ready      = 1'b0;

        // Reset is held low, then the block runs its clearing pass
        // and holds ready low until it is done, which send_dgram waits out.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, listen_port at reset value.
        foreach (dir_rows[r])
            send_dgram(dir_rows[r].dg, dir_rows[r].typed, dir_rows[r].want);

        // Session churn from a small client pool: clients that share an address
        // or a port, counts on open sessions, exits (some before any message),
        // and some noise. Idling switches on and off in stretches.
        set_listen_port(PORT_W'($urandom_range(1, 16'hFFFE)));
        for (int k = 0; k < POOL; k++) begin
            pool_addr[k] = (k % 2 == 1) ? pool_addr[k - 1] : ADDR_W'($urandom);
            pool_port[k] = (k % 4 == 2) ? pool_port[k - 2] : PORT_W'($urandom);
        end
        for (int k = 0; k < 300; k++) begin
            if (k % 60 == 0) begin
                gaps_on   = 1'($urandom);
                stalls_on = 1'($urandom);
            end
            pick = $urandom_range(0, POOL - 1);
            case ($urandom_range(0, 19))
                0, 1, 2: dg = noise_dgram();
                3, 4, 5: dg = client_dgram(pool_addr[pick], pool_port[pick], QUIT);
                default: dg = client_dgram(pool_addr[pick], pool_port[pick], MSG);
            endcase
            send_dgram(dg, PRED, ANY_REPLY);
        end

        // Top port value; fill the table to the last slot, then push it
        // against full: new clients get rejected until an exit frees a slot.
        set_listen_port(16'hFFFF);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        while (n_open < TABLE_ENTRIES)
            send_dgram(client_dgram(ADDR_W'($urandom), PORT_W'($urandom), MSG),
                       PRED, ANY_REPLY);
        for (int k = 0; k < 60; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    dg = client_dgram(ADDR_W'($urandom), PORT_W'($urandom), MSG);
                8, 9, 10, 11, 12: dg = open_client(MSG);
                13, 14, 15, 16:   dg = open_client(QUIT);
                default:          dg = noise_dgram();
            endcase
            send_dgram(dg, PRED, ANY_REPLY);
        end

        // Another port; drain sessions with a mix of traffic. The tail runs
        // with both sides at full speed.
        set_listen_port(PORT_W'($urandom_range(1, 16'hFFFE)));
        while (n_taken < ITEMS) begin
            if (n_taken >= ITEMS - CALM_TAIL) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: dg = open_client(QUIT);
                9, 10, 11, 12, 13:          dg = open_client(MSG);
                14, 15, 16:
                    dg = client_dgram(ADDR_W'($urandom), PORT_W'($urandom), MSG);
                default:                    dg = noise_dgram();
            endcase
            send_dgram(dg, PRED, ANY_REPLY);
        end
        in_if.valid <= 1'b0;

        // Wait for the last replies, then a little longer to catch strays.
        waited = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0)
            note_error($sformatf("%0d replies never arrived", pending_replies.size()));
        repeat (40) @(negedge i_clk);

        $display("Ran %0d datagrams on four listen ports, %0d replies checked, %0d errors",
                 n_taken, n_checked, n_errors);
        $display("Status: %0d counted, %0d filtered, %0d closed, %0d unknown exit, %0d full",
                 status_tally[ST_COUNTED], status_tally[ST_FILTERED],
                 status_tally[ST_CLOSED], status_tally[ST_EXIT_UNKNOWN],
                 status_tally[ST_FULL]);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
